@@ rtl/pid_pkg.sv @@
// pid_pkg: shared types and constants for the pid controller step block
// no dependencies

package pid_pkg;

    localparam int unsigned ONE_Q16 = 65536;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_POS   = 2'd1,
        MODE_SPEED = 2'd2,
        MODE_RSVD  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_KP     = 3'd1,
        REG_PCLAMP = 3'd2,
        REG_KI     = 3'd3,
        REG_ICLAMP = 3'd4,
        REG_KD     = 3'd5,
        REG_DFILT  = 3'd6,
        REG_OLIM   = 3'd7
    } reg_idx_t;

    // sequencer steps; each names the datapath operation for that step
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_PMUL,
        ST_IACC,
        ST_IMUL,
        ST_DSUB,
        ST_DDIV,
        ST_DFLT,
        ST_DMIX,
        ST_DMUL,
        ST_SUM,
        ST_LIM,
        ST_ACC1,
        ST_ACC2,
        ST_DONE,
        ST_OUT
    } state_t;

    typedef struct packed {
        state_t op;
        logic   div_start;
    } pid_cmd_t;

    typedef struct packed {
        logic div_done;
    } pid_stat_t;

endpackage

@@ rtl/pid_div.sv @@
// pid_div: restoring divider, one quotient bit per cycle, truncating toward zero
// depends on nothing

module pid_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num_mag,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quot,
    output logic             done
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   r_reg, r_next;
    logic [DEN_W-1:0] d_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        if (start)
        begin
            q_next    = num_mag;
            r_next    = '0;
            cnt_next  = CW'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
            d_reg <= den;
    end

    assign quot = q_reg;
    assign done = done_reg;
endmodule

@@ rtl/pid_ctrl.sv @@
// pid_ctrl: sequencer state machine for one controller step
// depends on pid_pkg

module pid_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  out_ready,
    input  logic                  d_enabled,
    input  logic                  accel_on,
    input  pid_pkg::pid_stat_t    stat,
    output pid_pkg::pid_cmd_t     cmd,
    output logic                  in_ready,
    output logic                  out_valid
);
    pid_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pid_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd.op        = state_reg;
        cmd.div_start = 1'b0;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        case (state_reg)
            pid_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = pid_pkg::ST_ERR;
            end
            pid_pkg::ST_ERR:  state_next = pid_pkg::ST_PMUL;
            pid_pkg::ST_PMUL: state_next = pid_pkg::ST_IACC;
            pid_pkg::ST_IACC: state_next = pid_pkg::ST_IMUL;
            pid_pkg::ST_IMUL:
                state_next = d_enabled ? pid_pkg::ST_DSUB : pid_pkg::ST_DFLT;
            pid_pkg::ST_DSUB:
            begin
                cmd.div_start = 1'b1;
                state_next    = pid_pkg::ST_DDIV;
            end
            pid_pkg::ST_DDIV:
                if (stat.div_done)
                    state_next = pid_pkg::ST_DFLT;
            pid_pkg::ST_DFLT:
                state_next = d_enabled ? pid_pkg::ST_DMIX : pid_pkg::ST_DMUL;
            pid_pkg::ST_DMIX: state_next = pid_pkg::ST_DMUL;
            pid_pkg::ST_DMUL: state_next = pid_pkg::ST_SUM;
            pid_pkg::ST_SUM:  state_next = pid_pkg::ST_LIM;
            pid_pkg::ST_LIM:
                state_next = accel_on ? pid_pkg::ST_ACC1 : pid_pkg::ST_DONE;
            pid_pkg::ST_ACC1: state_next = pid_pkg::ST_ACC2;
            pid_pkg::ST_ACC2: state_next = pid_pkg::ST_DONE;
            pid_pkg::ST_DONE: state_next = pid_pkg::ST_OUT;
            pid_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                // in OUT a new item is taken only together with the result transfer
                in_ready  = out_ready;
                if (out_ready)
                    state_next = in_valid ? pid_pkg::ST_ERR : pid_pkg::ST_IDLE;
            end
            default: state_next = pid_pkg::ST_IDLE;
        endcase
    end
endmodule

@@ rtl/pid_dp.sv @@
// pid_dp: datapath with shared multiplier, adders and state registers
// depends on pid_pkg and pid_div

module pid_dp #(
    parameter int          DATA_WIDTH = 32,
    parameter int unsigned DEADBAND   = 0,
    parameter int unsigned ACCEL_STEP = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pid_pkg::pid_cmd_t  cmd,
    output pid_pkg::pid_stat_t stat,
    input  logic               in_fire,
    input  logic signed [31:0] measured,
    input  logic signed [31:0] target,
    input  logic [30:0]        time_step,
    input  logic [1:0]         mode,
    input  logic signed [31:0] kp,
    input  logic [30:0]        pclamp,
    input  logic signed [31:0] ki,
    input  logic [30:0]        iclamp,
    input  logic signed [31:0] kd,
    input  logic [16:0]        dfilt,
    input  logic [30:0]        olim,
    output logic               d_enabled,
    output logic signed [31:0] drive,
    output logic [31:0]        settled_time
);
    localparam int WW = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam logic signed [65:0] WMAX = 66'sd1 <<< (WW - 1);
    localparam logic signed [65:0] HI   = WMAX - 66'sd1;
    localparam logic signed [65:0] LO   = -WMAX;

    function automatic logic signed [31:0] sat66(input logic signed [65:0] x);
        logic signed [65:0] y;
        begin
            y = x;
            if (x > HI) y = HI;
            if (x < LO) y = LO;
            sat66 = y[31:0];
        end
    endfunction

    function automatic logic signed [31:0] clampsym(input logic signed [31:0] x,
                                                    input logic [30:0] lim);
        logic signed [32:0] l, v, r;
        begin
            l = {2'b00, lim};
            v = {x[31], x};
            r = v;
            if (lim != '0)
            begin
                if (v > l) r = l;
                if (v < -l) r = -l;
            end
            clampsym = r[31:0];
        end
    endfunction

    logic signed [31:0] meas_reg, targ_reg;
    logic [31:0]        dt_reg;
    logic signed [31:0] err_reg, isum_reg, dst_reg, lerr_reg, ldrv_reg;
    logic [31:0]        zet_reg;
    logic signed [31:0] pterm_reg, iterm_reg, dterm_reg, out_reg, q_reg;
    logic               qneg_reg;
    logic signed [31:0] drive_reg;
    logic signed [65:0] acc_reg;

    // shared multiplier
    logic signed [32:0] ma, mb;
    logic signed [65:0] prod;
    logic signed [65:0] prod_fl;
    logic signed [31:0] perr;

    logic [48:0] div_q;
    logic        div_done;
    logic signed [32:0] dt_s;

    assign dt_s = {1'b0, dt_reg};
    assign d_enabled = (dfilt != '0) && (dfilt <= 17'(pid_pkg::ONE_Q16));
    assign perr = clampsym(err_reg, pclamp);

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            pid_pkg::ST_PMUL: begin ma = {kp[31], kp}; mb = {perr[31], perr}; end
            pid_pkg::ST_IACC: begin ma = {err_reg[31], err_reg}; mb = dt_s; end
            pid_pkg::ST_IMUL: begin ma = {ki[31], ki}; mb = {isum_reg[31], isum_reg}; end
            pid_pkg::ST_DFLT: begin ma = {dst_reg[31], dst_reg};
                mb = 33'(pid_pkg::ONE_Q16) - {16'd0, dfilt}; end
            pid_pkg::ST_DMIX: begin ma = {q_reg[31], q_reg}; mb = {16'd0, dfilt}; end
            pid_pkg::ST_DMUL: begin ma = {dst_reg[31], dst_reg}; mb = {kd[31], kd}; end
            pid_pkg::ST_ACC1: begin ma = 33'(ACCEL_STEP); mb = dt_s; end
            default: ;
        endcase
    end

    assign prod    = ma * mb;
    assign prod_fl = prod >>> 16;

    logic signed [32:0] dsub;
    logic [32:0]        dmag;
    assign dsub = {err_reg[31], err_reg} - {lerr_reg[31], lerr_reg};
    assign dmag = dsub[32] ? 33'(-dsub) : 33'(dsub);

    pid_div #(.NUM_W(49), .DEN_W(32)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .num_mag ({dmag, 16'd0}),
        .den     (dt_reg),
        .quot    (div_q),
        .done    (div_done)
    );
    assign stat.div_done = div_done;

    logic signed [65:0] e66, s66, q66;
    logic signed [31:0] isum_new;
    logic signed [31:0] acc_lim, hi_l, lo_l;
    logic [32:0]        zsum;

    always_comb
    begin
        e66 = 66'(targ_reg) - 66'(meas_reg);
        s66 = 66'(isum_reg) + prod_fl;
        isum_new = clampsym(sat66(s66), iclamp);
        q66 = qneg_reg ? -$signed({17'd0, div_q}) : $signed({17'd0, div_q});
        // acc_reg holds the acceleration step from ACC1
        hi_l = sat66(66'(ldrv_reg) + acc_reg);
        lo_l = sat66(66'(ldrv_reg) - acc_reg);
        acc_lim = out_reg;
        if (acc_lim > hi_l) acc_lim = hi_l;
        if (acc_lim < lo_l) acc_lim = lo_l;
        zsum = {1'b0, zet_reg} + {1'b0, dt_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            isum_reg <= '0;
            dst_reg  <= '0;
            lerr_reg <= '0;
            ldrv_reg <= '0;
            zet_reg  <= '0;
        end
        else
        begin
            case (cmd.op)
                pid_pkg::ST_IACC: isum_reg <= isum_new;
                pid_pkg::ST_DFLT:
                    if (!d_enabled) dst_reg <= '0;
                // commit filtered derivative state
                pid_pkg::ST_DMIX: dst_reg <= sat66((acc_reg + prod) >>> 16);
                pid_pkg::ST_DONE:
                begin
                    lerr_reg <= err_reg;
                    ldrv_reg <= out_reg;
                    if (err_reg == '0)
                        zet_reg <= zsum[32] ? 32'hFFFF_FFFF : zsum[31:0];
                    else
                        zet_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            meas_reg <= measured;
            targ_reg <= target;
            dt_reg   <= (time_step == '0) ? 32'(pid_pkg::ONE_Q16) : {1'b0, time_step};
        end
        case (cmd.op)
            pid_pkg::ST_ERR:
            begin
                err_reg <= sat66(e66);
                if ($signed(sat66(e66)) <= $signed(33'(DEADBAND)) &&
                    $signed(sat66(e66)) >= -$signed(33'(DEADBAND)))
                    err_reg <= '0;
            end
            pid_pkg::ST_PMUL: pterm_reg <= sat66(prod_fl);
            pid_pkg::ST_IMUL: iterm_reg <= sat66(prod_fl);
            pid_pkg::ST_DSUB: qneg_reg <= dsub[32];
            pid_pkg::ST_DDIV:
                if (div_done) q_reg <= sat66(q66);
            pid_pkg::ST_DFLT: acc_reg <= prod;
            pid_pkg::ST_DMUL: dterm_reg <= sat66(prod_fl);
            pid_pkg::ST_SUM:
                case (mode)
                    pid_pkg::MODE_POS:
                        out_reg <= sat66(66'(pterm_reg) + 66'(iterm_reg) - 66'(dterm_reg));
                    pid_pkg::MODE_SPEED:
                        out_reg <= sat66(66'(ldrv_reg) + 66'(pterm_reg)
                                         + 66'(iterm_reg) - 66'(dterm_reg));
                    default: out_reg <= ldrv_reg;
                endcase
            pid_pkg::ST_LIM:  out_reg <= clampsym(out_reg, olim);
            pid_pkg::ST_ACC1: acc_reg <= prod_fl;
            pid_pkg::ST_ACC2: out_reg <= acc_lim;
            pid_pkg::ST_DONE:
                drive_reg <= (mode == pid_pkg::MODE_POS || mode == pid_pkg::MODE_SPEED)
                             ? out_reg : '0;
            default: ;
        endcase
    end

    assign drive        = drive_reg;
    assign settled_time = zet_reg;
endmodule

@@ rtl/pid_controller_step.sv @@
// pid_controller_step: top level, registers, handshakes, sequencer and datapath
// depends on pid_pkg, pid_ctrl, pid_dp

//  channel | signals                         | direction
//  in      | in_valid/in_ready, fields       | into block
//  out     | out_valid/out_ready, fields     | out of block
//  cfg     | cfg_valid/cfg_ready, idx, data  | into block
//
// an item steps ERR, PMUL, IACC, IMUL, DFLT, DMUL, SUM, LIM, DONE, OUT;
// the derivative adds DSUB, DDIV and DMIX around the restoring divider for (error -
// last error) / dt at one quotient bit a cycle; acceleration limiting adds ACC1, ACC2
// reset clears mode, gains, clamps and loop state (integral, filter, last error and drive, settled time) to zero
// a result waits in the output register and holds the input off; the next item
// transfers with the result, so a new item goes in only as the last result goes out

module pid_controller_step #(
    parameter int          DATA_WIDTH = 32,
    parameter int unsigned DEADBAND   = 0,
    parameter int unsigned ACCEL_STEP = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] measured,
    input  logic signed [31:0] target,
    input  logic [30:0]        time_step,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] drive,
    output logic [31:0]        settled_time,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    logic [1:0]         mode_reg;
    logic signed [31:0] kp_reg, ki_reg, kd_reg;
    logic [30:0]        pcl_reg, icl_reg, olim_reg;
    logic [16:0]        dfilt_reg;

    pid_pkg::pid_cmd_t  cmd;
    pid_pkg::pid_stat_t stat;
    logic               d_enabled;
    logic               in_fire;

    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid & in_ready;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= '0;
            kp_reg    <= '0;
            pcl_reg   <= '0;
            ki_reg    <= '0;
            icl_reg   <= '0;
            kd_reg    <= '0;
            dfilt_reg <= '0;
            olim_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (pid_pkg::reg_idx_t'(cfg_index))
                pid_pkg::REG_MODE:   mode_reg  <= cfg_data[1:0];
                pid_pkg::REG_KP:     kp_reg    <= cfg_data;
                pid_pkg::REG_PCLAMP: pcl_reg   <= cfg_data[30:0];
                pid_pkg::REG_KI:     ki_reg    <= cfg_data;
                pid_pkg::REG_ICLAMP: icl_reg   <= cfg_data[30:0];
                pid_pkg::REG_KD:     kd_reg    <= cfg_data;
                pid_pkg::REG_DFILT:  dfilt_reg <= cfg_data[16:0];
                pid_pkg::REG_OLIM:   olim_reg  <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    pid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .d_enabled (d_enabled),
        .accel_on  (ACCEL_STEP != 0),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    pid_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .DEADBAND   (DEADBAND),
        .ACCEL_STEP (ACCEL_STEP)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_fire      (in_fire),
        .measured     (measured),
        .target       (target),
        .time_step    (time_step),
        .mode         (mode_reg),
        .kp           (kp_reg),
        .pclamp       (pcl_reg),
        .ki           (ki_reg),
        .iclamp       (icl_reg),
        .kd           (kd_reg),
        .dfilt        (dfilt_reg),
        .olim         (olim_reg),
        .d_enabled    (d_enabled),
        .drive        (drive),
        .settled_time (settled_time)
    );
endmodule
